@@ sv/nm3_pkg.sv @@
// Shared types, constants and helpers for the normal matrix block.
// No dependencies; used by normal_matrix_3x3 and nm3_chk.
package nm3_pkg;

    localparam int DW        = 32;
    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic signed [DW-1:0] a11;
        logic signed [DW-1:0] a21;
        logic signed [DW-1:0] a31;
        logic signed [DW-1:0] a12;
        logic signed [DW-1:0] a22;
        logic signed [DW-1:0] a32;
        logic signed [DW-1:0] a13;
        logic signed [DW-1:0] a23;
        logic signed [DW-1:0] a33;
    } mat_t;

    typedef struct packed {
        logic signed [DW-1:0] n11;
        logic signed [DW-1:0] n21;
        logic signed [DW-1:0] n31;
        logic signed [DW-1:0] n12;
        logic signed [DW-1:0] n22;
        logic signed [DW-1:0] n32;
        logic signed [DW-1:0] n13;
        logic signed [DW-1:0] n23;
        logic signed [DW-1:0] n33;
        logic                 singular;
    } nrm_t;

    // elements in column order, index 0 = a11
    typedef logic [8:0][DW-1:0] earr_t;

    // cofactor k = e[p]*e[q] - e[r]*e[s]
    localparam int COF_TAB [9][4] = '{
        '{8, 4, 5, 7}, '{2, 7, 8, 1}, '{5, 1, 2, 4},
        '{5, 6, 8, 3}, '{8, 0, 2, 6}, '{2, 3, 5, 0},
        '{7, 3, 4, 6}, '{1, 6, 7, 0}, '{4, 0, 1, 3}
    };

    // output position -> element (transpose)
    localparam int OUT_MAP [9] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

    function automatic earr_t mat_to_arr(mat_t m);
        earr_t r;
        r[0] = m.a11;
        r[1] = m.a21;
        r[2] = m.a31;
        r[3] = m.a12;
        r[4] = m.a22;
        r[5] = m.a32;
        r[6] = m.a13;
        r[7] = m.a23;
        r[8] = m.a33;
        return r;
    endfunction

endpackage

@@ sv/normal_matrix_3x3.sv @@
// Normal matrix (inverse transpose) of a 3x3 Q16.16 matrix, pipelined.
// Depends on nm3_pkg.
// Throughput: one matrix per cycle while the pipeline is not stalled; one restoring quotient bit per stage.
// Stalls back up stage by stage; empty stages keep accepting.
// Reset (rst_n low, asynchronous) clears all valid bits; data is not reset.
module normal_matrix_3x3 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mat_valid,
    output logic          mat_ready,
    input  nm3_pkg::mat_t mat,
    output logic          nrm_valid,
    input  logic          nrm_ready,
    output nm3_pkg::nrm_t nrm
);
    import nm3_pkg::*;

    localparam int PW   = 2*DW;
    localparam int CW   = 2*DW + 1;
    localparam int XW   = 2*DW + 1;
    localparam int DTW  = 3*DW + 3;
    localparam int RW   = DTW;
    localparam int DIV0 = 7;
    localparam int NST  = DIV0 + DW + 1;

    typedef struct packed {
        logic [8:0][RW-1:0] rem;
        logic [8:0][DW-1:0] q;
        logic [8:0][DW-1:0] nlo;
        logic [8:0]         neg;
        logic [8:0]         ovf;
        logic [RW-1:0]      dmag;
        logic               sing;
    } dv_t;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST:0]   en;

    mat_t                  raw_reg [NST-1];
    logic signed [PW-1:0]  p1_reg [9];
    logic signed [PW-1:0]  p2_reg [9];
    logic [CW-1:0]         cof_reg [9];
    logic signed [XW-1:0]  pl_reg [3];
    logic signed [XW-1:0]  ph_reg [3];
    logic [CW-1:0]         cmag_reg [2:5][9];
    logic [8:0]            cneg_reg [2:5];
    logic [DTW-1:0]        dt_reg [3];
    logic [DTW-1:0]        det_reg;
    logic [RW-1:0]         dmag_reg;
    logic                  dneg_reg;
    logic                  sing_reg;
    logic [RW-1:0]         hnum [9];
    dv_t                   dv_reg [DIV0-1:NST-2];
    nrm_t                  out_reg;
    nrm_t                  out_next;

    earr_t e0;
    earr_t e2;
    earr_t eo;

    assign en[NST] = nrm_ready;
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = ~v_reg[k] | en[k+1];
    end

    assign v_next    = {v_reg[NST-2:0], mat_valid};
    assign mat_ready = en[0];
    assign nrm_valid = v_reg[NST-1];
    assign nrm       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            raw_reg[0] <= mat;
        end
        for (int k = 1; k < NST-1; k++)
        begin
            if (en[k])
            begin
                raw_reg[k] <= raw_reg[k-1];
            end
        end
    end

    assign e0 = mat_to_arr(mat);
    assign e2 = mat_to_arr(raw_reg[1]);
    assign eo = mat_to_arr(raw_reg[NST-2]);

    // stage 0: cofactor products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int g = 0; g < 9; g++)
            begin
                p1_reg[g] <= $signed(e0[COF_TAB[g][0]]) * $signed(e0[COF_TAB[g][1]]);
                p2_reg[g] <= $signed(e0[COF_TAB[g][2]]) * $signed(e0[COF_TAB[g][3]]);
            end
        end
    end

    // stage 1: cofactors
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int g = 0; g < 9; g++)
            begin
                cof_reg[g] <= {p1_reg[g][PW-1], p1_reg[g]} - {p2_reg[g][PW-1], p2_reg[g]};
            end
        end
    end

    // stage 2: determinant partial products, cofactor magnitudes by output position
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                pl_reg[j] <= $signed(e2[j]) * $signed({1'b0, cof_reg[3*j][DW-1:0]});
                ph_reg[j] <= $signed(e2[j]) * $signed(cof_reg[3*j][CW-1:DW]);
            end
            for (int k = 0; k < 9; k++)
            begin
                cneg_reg[2][k] <= cof_reg[OUT_MAP[k]][CW-1];
                cmag_reg[2][k] <= cof_reg[OUT_MAP[k]][CW-1] ? -cof_reg[OUT_MAP[k]]
                                                             : cof_reg[OUT_MAP[k]];
            end
        end
    end

    for (genvar s = 3; s <= 5; s++) begin : g_cdly
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                cmag_reg[s] <= cmag_reg[s-1];
                cneg_reg[s] <= cneg_reg[s-1];
            end
        end
    end

    // stage 3: per-term sums
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int j = 0; j < 3; j++)
            begin
                dt_reg[j] <= ({{(DTW-XW){ph_reg[j][XW-1]}}, ph_reg[j]} << DW)
                           + {{(DTW-XW){pl_reg[j][XW-1]}}, pl_reg[j]};
            end
        end
    end

    // stage 4: determinant
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            det_reg <= dt_reg[0] + dt_reg[1] + dt_reg[2];
        end
    end

    // stage 5: determinant magnitude and zero test
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            dneg_reg <= det_reg[DTW-1];
            dmag_reg <= det_reg[DTW-1] ? -det_reg : det_reg;
            sing_reg <= (det_reg == '0);
        end
    end

    // upper numerator bits: cofactor magnitude scaled by 2^(2*FRAC_BITS-DW)
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            hnum[k] = RW'(cmag_reg[5][k]) << (2*FRAC_BITS - DW);
        end
    end

    // stage 6: overflow test and first partial remainder
    always_ff @(posedge clk)
    begin
        if (en[DIV0-1])
        begin
            for (int k = 0; k < 9; k++)
            begin
                dv_reg[DIV0-1].rem[k] <= hnum[k];
                dv_reg[DIV0-1].nlo[k] <= '0;
                dv_reg[DIV0-1].ovf[k] <= (hnum[k] >= dmag_reg);
            end
            dv_reg[DIV0-1].q    <= '0;
            dv_reg[DIV0-1].neg  <= cneg_reg[5] ^ {9{dneg_reg}};
            dv_reg[DIV0-1].dmag <= dmag_reg;
            dv_reg[DIV0-1].sing <= sing_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar s = DIV0; s <= NST-2; s++) begin : g_div
        dv_t          dv_next;
        logic [RW:0]  t [9];
        logic [8:0]   ge;

        always_comb
        begin
            dv_next = dv_reg[s-1];
            for (int k = 0; k < 9; k++)
            begin
                t[k]  = {dv_reg[s-1].rem[k], dv_reg[s-1].nlo[k][DW-1]};
                ge[k] = (t[k] >= {1'b0, dv_reg[s-1].dmag});
                dv_next.rem[k] = ge[k] ? RW'(t[k] - {1'b0, dv_reg[s-1].dmag})
                                       : t[k][RW-1:0];
                dv_next.q[k]   = {dv_reg[s-1].q[k][DW-2:0], ge[k]};
                dv_next.nlo[k] = {dv_reg[s-1].nlo[k][DW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                dv_reg[s] <= dv_next;
            end
        end
    end

    // output: round half away from zero, saturate, or plain transpose
    logic [DW-1:0] nv [9];
    logic [DW:0]   qr [9];
    logic [8:0]    rnd;
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW:0]   LIM  = {2'b01, {(DW-1){1'b0}}};

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            rnd[k] = ({dv_reg[NST-2].rem[k], 1'b0} >= {1'b0, dv_reg[NST-2].dmag});
            qr[k]  = {1'b0, dv_reg[NST-2].q[k]} + {{DW{1'b0}}, rnd[k]};
            if (dv_reg[NST-2].sing)
            begin
                nv[k] = eo[OUT_MAP[k]];
            end
            else if (dv_reg[NST-2].ovf[k])
            begin
                nv[k] = dv_reg[NST-2].neg[k] ? MINV : MAXV;
            end
            else if (!dv_reg[NST-2].neg[k])
            begin
                nv[k] = (qr[k] > {1'b0, MAXV}) ? MAXV : qr[k][DW-1:0];
            end
            else
            begin
                nv[k] = (qr[k] > LIM) ? MINV : -qr[k][DW-1:0];
            end
        end
        out_next.n11      = nv[0];
        out_next.n21      = nv[1];
        out_next.n31      = nv[2];
        out_next.n12      = nv[3];
        out_next.n22      = nv[4];
        out_next.n32      = nv[5];
        out_next.n13      = nv[6];
        out_next.n23      = nv[7];
        out_next.n33      = nv[8];
        out_next.singular = dv_reg[NST-2].sing;
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

@@ sv/nm3_chk.sv @@
// Port-level checks for normal_matrix_3x3, attached by bind.
// Depends on nm3_pkg.
module nm3_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          mat_valid,
    input logic          mat_ready,
    input logic          nrm_valid,
    input logic          nrm_ready,
    input nm3_pkg::nrm_t nrm
);

    a_rst_empty: assert property (@(posedge clk) !rst_n |=> !nrm_valid)
        else $error("result valid during reset");

    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_ready |-> mat_ready)
        else $error("input stalled while output drains");

    a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        !nrm_valid |-> mat_ready)
        else $error("input stalled with empty output stage");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_valid && !nrm_ready |=> nrm_valid && $stable(nrm))
        else $error("stalled result changed");

endmodule

bind normal_matrix_3x3 nm3_chk u_nm3_chk (.*);
